// ----- design/wfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wfd_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int KIND_W = 3;

   // Header fields and codes.
   localparam logic [3:0]       OP_TEXT     = 4'h1;
   localparam logic [3:0]       OP_BIN      = 4'h2;
   localparam logic [3:0]       OP_CLOSE    = 4'h8;
   localparam logic [LEN_W-1:0] LEN_CAP     = 7'd125;
   localparam logic [LEN_W-1:0] MAX_PAY_RST = 7'd80;

   // Configuration register indexes.
   localparam logic REG_MAX_PAYLOAD = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE  = 3'd0,
      KIND_EMPTY = 3'd1,
      KIND_CLOSE = 3'd2,
      KIND_LONG  = 3'd3,
      KIND_FRAG  = 3'd4
   } kind_type;

   // One classified item passed from the front end to the back end.
   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] mask;
      logic              last;
      logic              is_binary;
   } cmd_type;

endpackage

// ----- design/wfd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_front
// Header parser: tracks the frame phase and turns each byte into zero or one
// classified command for the back end.
// ----------------------------------------------------------------------------
module wfd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_valid,
   input  logic [7:0]              rx_byte,
   input  logic [6:0]              max_payload,
   output logic                    cmd_push,
   output wfd_pkg::cmd_type        cmd
);
   import wfd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR1  = 3'd0,
      PH_HDR2  = 3'd1,
      PH_MASK0 = 3'd2,
      PH_MASK1 = 3'd3,
      PH_MASK2 = 3'd4,
      PH_MASK3 = 3'd5,
      PH_DATA  = 3'd6
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic              fin_ff, fin_in;
   logic [3:0]        opcode_ff, opcode_in;
   logic              masked_ff, masked_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  index_ff, index_in;
   logic [BYTE_W-1:0] key_ff [4];
   logic [BYTE_W-1:0] key_in [4];

   logic [LEN_W-1:0]  limit;
   logic [LEN_W-1:0]  len_field;
   logic [LEN_W-1:0]  index_next;
   logic              data_end;
   logic              is_data;
   logic              is_bin;
   logic              fe_push;
   kind_type          fe_kind;

   assign limit      = (max_payload > LEN_CAP) ? LEN_CAP : max_payload;
   assign len_field  = rx_byte[LEN_W-1:0];
   assign index_next = index_ff + 7'd1;
   assign data_end   = (index_next >= length_ff);
   assign is_bin     = (opcode_ff == OP_BIN);
   assign is_data    = (opcode_ff == OP_TEXT) || is_bin;

   // Result of a frame that ends without a payload byte to carry it.
   always_comb begin
      fe_push = 1'b1;
      fe_kind = KIND_FRAG;
      priority if (!fin_ff) begin
         fe_kind = KIND_FRAG;
      end else if (is_data) begin
         fe_kind = KIND_EMPTY;
      end else if (opcode_ff == OP_CLOSE) begin
         fe_kind = KIND_CLOSE;
      end else begin
         fe_push = 1'b0;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      length_in = length_ff;
      index_in  = index_ff;
      key_in    = key_ff;
      cmd_push  = 1'b0;
      cmd       = '{kind: KIND_BYTE, data: '0, mask: '0, last: 1'b0, is_binary: 1'b0};
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HDR1: begin
               opcode_in = rx_byte[3:0];
               fin_in    = rx_byte[7];
               phase_in  = PH_HDR2;
            end
            PH_HDR2: begin
               if (len_field > limit) begin
                  phase_in = PH_HDR1;
                  cmd_push = 1'b1;
                  cmd.kind = KIND_LONG;
               end else begin
                  masked_in = rx_byte[7];
                  length_in = len_field;
                  index_in  = '0;
                  if (rx_byte[7]) begin
                     phase_in = PH_MASK0;
                  end else if (len_field == '0) begin
                     phase_in      = PH_HDR1;
                     cmd_push      = fe_push;
                     cmd.kind      = fe_kind;
                     cmd.is_binary = (fe_kind == KIND_EMPTY) && is_bin;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_MASK0, PH_MASK1, PH_MASK2: begin
               key_in[2'(phase_ff - PH_MASK0)] = rx_byte;
               phase_in = phase_type'(phase_ff + 3'd1);
            end
            PH_MASK3: begin
               key_in[3] = rx_byte;
               if (length_ff == '0) begin
                  phase_in      = PH_HDR1;
                  cmd_push      = fe_push;
                  cmd.kind      = fe_kind;
                  cmd.is_binary = (fe_kind == KIND_EMPTY) && is_bin;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               index_in = index_next;
               if (data_end) begin
                  phase_in = PH_HDR1;
               end
               priority if (!fin_ff) begin
                  cmd_push = data_end;
                  cmd.kind = KIND_FRAG;
               end else if (is_data) begin
                  cmd_push      = 1'b1;
                  cmd.kind      = KIND_BYTE;
                  cmd.data      = rx_byte;
                  cmd.mask      = masked_ff ? key_ff[index_ff[1:0]] : '0;
                  cmd.last      = data_end;
                  cmd.is_binary = is_bin;
               end else begin
                  cmd_push = data_end && (opcode_ff == OP_CLOSE);
                  cmd.kind = KIND_CLOSE;
               end
            end
            default: begin
               phase_in = PH_HDR1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR1;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
         masked_ff <= 1'b0;
         length_ff <= '0;
         index_ff  <= '0;
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         length_ff <= length_in;
         index_ff  <= index_in;
         key_ff    <= key_in;
      end
   end

   // A first header byte always leads to the second header byte.
   a_hdr1_to_hdr2: assert property (@(posedge clock) disable iff (reset)
      byte_valid && (phase_ff == PH_HDR1) |=> (phase_ff == PH_HDR2))
      else $error("header byte did not advance the phase");

   // A length above the limit ends the frame at once.
   a_long_to_hdr1: assert property (@(posedge clock) disable iff (reset)
      byte_valid && (phase_ff == PH_HDR2) && (len_field > limit) |=> (phase_ff == PH_HDR1))
      else $error("too long header did not return to the first header byte");

   // While streaming payload the index stays below the frame length.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (index_ff < length_ff))
      else $error("payload index ran past the frame length");

endmodule

// ----- design/wfd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_queue
// Short register queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
module wfd_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wfd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output wfd_pkg::cmd_type head_cmd,
   output logic             full,
   output logic             empty
);
   import wfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count exceeds depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push without pop did not grow the queue");

   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop without push did not shrink the queue");

endmodule

// ----- design/wfd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_back
// Result stage: unmasks payload bytes and holds the oldest result until the
// consumer takes it.
// ----------------------------------------------------------------------------
module wfd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_avail,
   input  wfd_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_payload,
   output logic             rsp_last,
   output logic             rsp_is_binary
);
   import wfd_pkg::*;

   logic              valid_ff, valid_in;
   kind_type          kind_ff;
   logic [BYTE_W-1:0] payload_ff;
   logic              last_ff;
   logic              bin_ff;
   logic              take;

   // Refill the result register whenever it is free or being drained.
   assign take     = cmd_avail && (!valid_ff || rsp_pop);
   assign cmd_pop  = take;
   assign valid_in = take || (valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff    <= cmd.kind;
         payload_ff <= (cmd.kind == KIND_BYTE) ? (cmd.data ^ cmd.mask) : '0;
         last_ff    <= cmd.last;
         bin_ff     <= cmd.is_binary;
      end
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_payload   = payload_ff;
   assign rsp_last      = last_ff;
   assign rsp_is_binary = bin_ff;

endmodule

// ----- design/websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a received WebSocket byte stream and delivers unmasked payload
// bytes and frame events as result items.
// ----------------------------------------------------------------------------
//   Channel   Ports                                  Direction
//   req       req_push, req_full, req_rx_byte        in  (queue write side)
//   rsp       rsp_pop, rsp_empty, rsp_kind, ...      out (queue read side)
//   csr       csr_psel .. csr_pready                 APB, max_payload at 0x0
//
// One byte is taken every cycle while req_full is low. Each result passes
// through the command queue and then the result register to the rsp ports.
// req_full rises only when the command queue holds QUEUE_DEPTH items and the
// result register is waiting to be popped. Reset is synchronous; no clearing
// pass follows it.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_payload,
   output logic        rsp_last,
   output logic        rsp_is_binary,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wfd_pkg::*;

   logic [LEN_W-1:0] max_payload_ff;
   logic             csr_write;
   logic             csr_hit;
   logic             byte_valid;
   logic             cmd_push;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = (csr_paddr[2] == REG_MAX_PAYLOAD) && (csr_paddr[1:0] == 2'b00);
   assign csr_prdata = csr_hit ? {25'd0, max_payload_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAY_RST;
      end else if (csr_write && csr_hit) begin
         max_payload_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   assign req_full   = q_full;
   assign byte_valid = req_push && !q_full;

   wfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (byte_valid),
      .rx_byte     (req_rx_byte),
      .max_payload (max_payload_ff),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd)
   );

   wfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   wfd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_avail     (!q_empty),
      .cmd           (head_cmd),
      .cmd_pop       (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_kind      (rsp_kind),
      .rsp_payload   (rsp_payload),
      .rsp_last      (rsp_last),
      .rsp_is_binary (rsp_is_binary)
   );

endmodule

// ----- test/websocket_frame_deframer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_test
// Streams WebSocket frames into the deframer one byte per item, with a short
// directed opening and then random frames under several max_payload settings
// and idle patterns. A frame parser kept alongside the block predicts every
// result item, and each popped item is compared field by field with it.
// ----------------------------------------------------------------------------
import wfd_pkg::*;

typedef struct packed {
   kind_type   kind;
   logic [7:0] payload;
   logic       last;
   logic       is_binary;
} deframe_result_type;

class deframe_scoreboard;
   typedef enum logic [1:0] {WAIT_HDR1, WAIT_HDR2, WAIT_MASK, WAIT_DATA} parse_type;

   parse_type          parse_st;
   logic [6:0]         max_len;
   logic               fin;
   logic [3:0]         opcode;
   logic               masked;
   logic [6:0]         frame_len;
   logic [6:0]         pos;
   logic [1:0]         key_pos;
   logic [7:0]         key [4];
   deframe_result_type expected_results [$];
   int                 n_bytes;
   int                 n_checked;
   int                 n_errors;
   int                 kind_count [5];

   function new();
      parse_st  = WAIT_HDR1;
      max_len   = MAX_PAY_RST;
      fin       = 1'b0;
      opcode    = '0;
      masked    = 1'b0;
      frame_len = '0;
      pos       = '0;
      key_pos   = '0;
      foreach (key[i]) key[i] = '0;
      n_bytes   = 0;
      n_checked = 0;
      n_errors  = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
   endfunction

   // Lengths 126 and 127 select extended length fields, which are never taken.
   function logic [6:0] length_cap();
      return (max_len > LEN_CAP) ? LEN_CAP : max_len;
   endfunction

   function void set_max_payload(logic [31:0] value);
      max_len = value[6:0];
   endfunction

   function int pending();
      return expected_results.size();
   endfunction

   function void add_result(kind_type k, logic [7:0] p, logic l, logic bin);
      deframe_result_type r;
      r.kind      = k;
      r.payload   = p;
      r.last      = l;
      r.is_binary = bin;
      expected_results.push_back(r);
   endfunction

   function logic is_data();
      return opcode == OP_TEXT || opcode == OP_BIN;
   endfunction

   // A frame that ends with no payload byte left to carry the event.
   function void end_empty_frame();
      parse_st = WAIT_HDR1;
      if (!fin)
         add_result(KIND_FRAG, 8'h00, 1'b0, 1'b0);
      else if (is_data())
         add_result(KIND_EMPTY, 8'h00, 1'b0, opcode == OP_BIN);
      else if (opcode == OP_CLOSE)
         add_result(KIND_CLOSE, 8'h00, 1'b0, 1'b0);
   endfunction

   function void note_byte(logic [7:0] b);
      logic [7:0] v;
      logic       done;
      n_bytes++;
      case (parse_st)
         WAIT_HDR1: begin
            opcode   = b[3:0];
            fin      = b[7];
            parse_st = WAIT_HDR2;
         end
         WAIT_HDR2: begin
            if (b[6:0] > length_cap()) begin
               // The rest of the frame is not skipped.
               add_result(KIND_LONG, 8'h00, 1'b0, 1'b0);
               parse_st = WAIT_HDR1;
            end else begin
               masked    = b[7];
               frame_len = b[6:0];
               pos       = '0;
               key_pos   = '0;
               if (masked)
                  parse_st = WAIT_MASK;
               else if (frame_len == 0)
                  end_empty_frame();
               else
                  parse_st = WAIT_DATA;
            end
         end
         WAIT_MASK: begin
            key[key_pos] = b;
            if (key_pos != 2'd3)
               key_pos++;
            else if (frame_len == 0)
               end_empty_frame();
            else
               parse_st = WAIT_DATA;
         end
         default: begin
            v    = masked ? (b ^ key[pos[1:0]]) : b;
            pos  = pos + 7'd1;
            done = pos >= frame_len;
            if (done) parse_st = WAIT_HDR1;
            if (!fin) begin
               if (done) add_result(KIND_FRAG, 8'h00, 1'b0, 1'b0);
            end else if (is_data()) begin
               add_result(KIND_BYTE, v, done, opcode == OP_BIN);
            end else if (done && opcode == OP_CLOSE) begin
               add_result(KIND_CLOSE, 8'h00, 1'b0, 1'b0);
            end
         end
      endcase
   endfunction

   function void check_result(logic [2:0] k, logic [7:0] p, logic l, logic bin);
      deframe_result_type want;
      if (expected_results.size() == 0) begin
         n_errors++;
         if (n_errors <= 10)
            $display("ERROR: unexpected result kind=%0d payload=%02h last=%0b bin=%0b",
                     k, p, l, bin);
         return;
      end
      want = expected_results.pop_front();
      n_checked++;
      if (want.kind <= KIND_FRAG) kind_count[want.kind]++;
      if (k !== want.kind || p !== want.payload || l !== want.last ||
          bin !== want.is_binary) begin
         n_errors++;
         if (n_errors <= 10) begin
            $display("ERROR: result %0d expected kind=%0d payload=%02h last=%0b bin=%0b",
                     n_checked, want.kind, want.payload, want.last, want.is_binary);
            $display("       got kind=%0d payload=%02h last=%0b bin=%0b",
                     k, p, l, bin);
         end
      end
   endfunction
endclass

module websocket_frame_deframer_test;

   localparam int         STALL_LIMIT      = 2000;
   localparam int         RANDOM_BYTES     = 1550;
   localparam int         NUM_PHASES       = 8;
   localparam logic [2:0] MAX_PAYLOAD_ADDR = 3'(4 * int'(REG_MAX_PAYLOAD));

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_push      = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte   = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop       = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_payload;
   logic        rsp_last;
   logic        rsp_is_binary;
   logic        csr_psel      = 1'b0;
   logic        csr_penable   = 1'b0;
   logic        csr_pwrite    = 1'b0;
   logic [2:0]  csr_paddr     = 3'd0;
   logic [31:0] csr_pwdata    = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int push_idle_pct = 0;
   int pop_stall_pct = 0;
   int idle_cycles   = 0;
   int bytes_sent    = 0;
   int frames_sent   = 0;

   deframe_scoreboard sb = new();

   // Masked text, unmasked binary, empty text, close, fragment, too long and
   // a final ping frame that gives no result.
   logic [7:0] directed_bytes [22] = '{
      8'h81, 8'h82, 8'hA5, 8'h00, 8'hFF, 8'h3C, 8'h5A, 8'hC3,
      8'h82, 8'h01, 8'hFF,
      8'h81, 8'h00,
      8'h88, 8'h00,
      8'h01, 8'h01, 8'h55,
      8'h82, 8'hFF,
      8'h89, 8'h00
   };

   websocket_frame_deframer uut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_rx_byte   (req_rx_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_kind      (rsp_kind),
      .rsp_payload   (rsp_payload),
      .rsp_last      (rsp_last),
      .rsp_is_binary (rsp_is_binary),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_push && !req_full)
         sb.note_byte(req_rx_byte);
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_result(rsp_kind, rsp_payload, rsp_last, rsp_is_binary);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_max_payload(data);
   endtask

   // A byte with no result may still be in flight when the queue drains.
   task automatic wait_quiet();
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_random_frame();
      int         pick;
      int         want_len;
      int         n_payload;
      logic [3:0] op;
      logic       fin;
      logic       msk;
      logic [6:0] len;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_byte(8'($urandom_range(255)));
         return;
      end
      pick = $urandom_range(9);
      if (pick < 4)      op = OP_TEXT;
      else if (pick < 7) op = OP_BIN;
      else if (pick < 8) op = OP_CLOSE;
      else               op = 4'($urandom_range(15));
      fin  = ($urandom_range(9) != 0);
      msk  = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 82) begin
         want_len = $urandom_range(6);
      end else if (pick < 90) begin
         // Straddle the current limit, including the extended length codes.
         want_len = int'(sb.length_cap()) + int'($urandom_range(3)) - 1;
         if (want_len < 0)   want_len = 0;
         if (want_len > 127) want_len = 127;
      end else begin
         want_len = $urandom_range(127);
      end
      len = 7'(want_len);
      frames_sent++;
      send_byte({fin, 3'($urandom_range(7)), op});
      send_byte({msk, len});
      if (len > sb.length_cap()) return;
      if (msk)
         repeat (4) send_byte(8'($urandom_range(255)));
      n_payload = int'(len);
      if ($urandom_range(19) == 0) n_payload = $urandom_range(n_payload);
      repeat (n_payload) send_byte(8'($urandom_range(255)));
   endtask

   initial begin
      logic [6:0] setting;
      int         target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      req_push <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: setting = 7'd0;
            1: setting = 7'd125;
            2: setting = 7'd127;
            3: setting = 7'd126;
            4: setting = 7'd1;
            6: setting = MAX_PAY_RST;
            default: setting = 7'($urandom_range(127));
         endcase
         case (p % 4)
            0: begin push_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin push_idle_pct = 62; pop_stall_pct = 0;  end
            2: begin push_idle_pct = 0;  pop_stall_pct = 62; end
            default: begin push_idle_pct = 24; pop_stall_pct = 24; end
         endcase
         wait_quiet();
         csr_write(MAX_PAYLOAD_ADDR, {25'($urandom), setting});
         target = (RANDOM_BYTES * (p + 1)) / NUM_PHASES + $size(directed_bytes);
         while (bytes_sent < target) send_random_frame();
         req_push <= 1'b0;
      end

      wait_quiet();
      repeat (12) @(posedge clock);

      $display("Sent %0d bytes in %0d random frames under %0d max_payload settings.",
               bytes_sent, frames_sent, NUM_PHASES);
      $display("Checked %0d results: %0d payload, %0d empty, %0d close, %0d too long, %0d fragment.",
               sb.n_checked, sb.kind_count[0], sb.kind_count[1], sb.kind_count[2],
               sb.kind_count[3], sb.kind_count[4]);
      if (sb.n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", sb.n_errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/wfd_pkg.sv
design/wfd_front.sv
design/wfd_queue.sv
design/wfd_back.sv
design/websocket_frame_deframer.sv
test/websocket_frame_deframer_test.sv
